[hw/rtl/tcrs_pkg.sv]
// Shared types and constants for the three-channel running statistics block.
// Used by three_channel_running_stats and by the testbench; depends on nothing else.
package tcrs_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int NUM_CHAN   = 3;
   localparam int CHAN_W     = 2;
   localparam int WINDOW_DEF = 16;

   localparam logic [CHAN_W-1:0] CHAN_TEMP  = 2'd0;
   localparam logic [CHAN_W-1:0] CHAN_PULSE = 2'd1;
   localparam logic [CHAN_W-1:0] CHAN_SPO2  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_DONE
   } tcrs_state_type;

endpackage

[hw/rtl/three_channel_running_stats.sv]
// Three-channel running statistics: top level, sequencer and statistics registers.
// Depends on tcrs_pkg, tcrs_ram and tcrs_div.
//
// Each accepted sample updates one channel in turn (temperature, pulse rate, SpO2)
// and appends all three held values to a history ring of WINDOW entries. The result
// carries, per channel, the all-time minimum and maximum and the mean of the last
// WINDOW entries (of all entries before the ring fills), truncated towards zero.
// The single restoring divider forms the three means one after another at one
// bit per cycle. The input is stalled while an item is in progress; a finished
// result waits in its own output register, so the next sample may be taken
// before it is collected.
module three_channel_running_stats
   import tcrs_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_temp_min,
   output logic signed [SAMPLE_W-1:0] rsp_pulse_min,
   output logic signed [SAMPLE_W-1:0] rsp_spo2_min,
   output logic signed [SAMPLE_W-1:0] rsp_temp_max,
   output logic signed [SAMPLE_W-1:0] rsp_pulse_max,
   output logic signed [SAMPLE_W-1:0] rsp_spo2_max,
   output logic signed [SAMPLE_W-1:0] rsp_temp_mean,
   output logic signed [SAMPLE_W-1:0] rsp_pulse_mean,
   output logic signed [SAMPLE_W-1:0] rsp_spo2_mean
);

   localparam int ADDR_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CNT_W   = $clog2(WINDOW + 1);
   localparam int SUM_W   = SAMPLE_W + $clog2(WINDOW);
   localparam int ENTRY_W = SAMPLE_W * NUM_CHAN;

   tcrs_state_type state_ff, state_in;

   logic [CHAN_W-1:0]          turn_ff, turn_in;
   logic [CHAN_W-1:0]          div_chan_ff, div_chan_in;
   logic [ADDR_W-1:0]          slot_ff, slot_in;
   logic [CNT_W-1:0]           fill_ff, fill_in;
   logic signed [SAMPLE_W-1:0] held_ff [NUM_CHAN];
   logic signed [SUM_W-1:0]    sums_ff [NUM_CHAN];
   logic signed [SAMPLE_W-1:0] min_ff  [NUM_CHAN];
   logic signed [SAMPLE_W-1:0] max_ff  [NUM_CHAN];
   logic signed [SAMPLE_W-1:0] mean_ff [NUM_CHAN];
   logic signed [SAMPLE_W-1:0] out_ff  [3 * NUM_CHAN];
   logic                       rsp_valid_ff, rsp_valid_in;

   logic                req_take;
   logic                rd_en;
   logic                upd_en;
   logic                div_start;
   logic                load_out;
   logic                full;
   logic                first;
   logic                last_chan;
   logic [ENTRY_W-1:0]  old_entry;
   logic [ENTRY_W-1:0]  new_entry;

   logic signed [SUM_W-1:0] div_sum;
   logic                    div_neg;
   logic [SUM_W-1:0]        div_dividend;
   logic                    div_done;
   logic [SUM_W-1:0]        div_quotient;
   logic [SAMPLE_W-1:0]     quo_low;
   logic [SAMPLE_W-1:0]     mean_value;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign full      = (fill_ff == CNT_W'(WINDOW));
   assign first     = (fill_ff == '0);
   assign last_chan = (div_chan_ff == CHAN_SPO2);
   assign new_entry = {held_ff[2], held_ff[1], held_ff[0]};

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE:    state_in = ST_DIV_START;
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = last_chan ? ST_DONE : ST_DIV_START;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      rd_en     = 1'b0;
      upd_en    = 1'b0;
      div_start = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         ST_IDLE:      rd_en     = req_take;
         ST_UPDATE:    upd_en    = 1'b1;
         ST_DIV_START: div_start = 1'b1;
         ST_DIV_WAIT:  load_out  = 1'b0;
         ST_DONE:      load_out  = !rsp_valid_ff || !rsp_stall;
         default:      load_out  = 1'b0;
      endcase
   end

   tcrs_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(WINDOW)
   ) u_history (
      .clock   (clock),
      .wr_en   (upd_en),
      .wr_addr (slot_ff),
      .wr_data (new_entry),
      .rd_en   (rd_en),
      .rd_addr (slot_ff),
      .rd_data (old_entry)
   );

   always_comb begin
      case (div_chan_ff)
         CHAN_TEMP:  div_sum = sums_ff[0];
         CHAN_PULSE: div_sum = sums_ff[1];
         CHAN_SPO2:  div_sum = sums_ff[2];
         default:    div_sum = sums_ff[0];
      endcase
   end

   assign div_neg      = div_sum[SUM_W-1];
   assign div_dividend = div_neg ? SUM_W'(-div_sum) : div_sum;

   tcrs_div #(
      .DIVIDEND_W(SUM_W),
      .DIVISOR_W (CNT_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (fill_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   assign quo_low    = div_quotient[SAMPLE_W-1:0];
   assign mean_value = div_neg ? (~quo_low + {{(SAMPLE_W-1){1'b0}}, 1'b1}) : quo_low;

   always_comb begin
      turn_in     = turn_ff;
      slot_in     = slot_ff;
      fill_in     = fill_ff;
      div_chan_in = div_chan_ff;
      if (req_take) begin
         turn_in = (turn_ff == CHAN_SPO2) ? CHAN_TEMP : turn_ff + 1'b1;
      end
      if (upd_en) begin
         slot_in     = (slot_ff == ADDR_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
         fill_in     = full ? fill_ff : fill_ff + 1'b1;
         div_chan_in = CHAN_TEMP;
      end
      if (div_done) begin
         div_chan_in = last_chan ? CHAN_TEMP : div_chan_ff + 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         turn_ff      <= CHAN_TEMP;
         slot_ff      <= '0;
         fill_ff      <= '0;
         div_chan_ff  <= CHAN_TEMP;
         rsp_valid_ff <= 1'b0;
         for (int c = 0; c < NUM_CHAN; c++) begin
            held_ff[c] <= '0;
            sums_ff[c] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         turn_ff      <= turn_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         div_chan_ff  <= div_chan_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int c = 0; c < NUM_CHAN; c++) begin
            if (req_take && (turn_ff == CHAN_W'(c))) begin
               held_ff[c] <= req_sample_value;
            end
            if (upd_en) begin
               sums_ff[c] <= sums_ff[c] + SUM_W'(held_ff[c])
                  - (full ? SUM_W'($signed(old_entry[SAMPLE_W*c +: SAMPLE_W]))
                          : SUM_W'(0));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         if (upd_en && (first || (held_ff[c] < min_ff[c]))) begin
            min_ff[c] <= held_ff[c];
         end
         if (upd_en && (first || (held_ff[c] > max_ff[c]))) begin
            max_ff[c] <= held_ff[c];
         end
         if (div_done && (div_chan_ff == CHAN_W'(c))) begin
            mean_ff[c] <= mean_value;
         end
         if (load_out) begin
            out_ff[c]                <= min_ff[c];
            out_ff[NUM_CHAN + c]     <= max_ff[c];
            out_ff[2 * NUM_CHAN + c] <= mean_ff[c];
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_temp_min   = out_ff[0];
   assign rsp_pulse_min  = out_ff[1];
   assign rsp_spo2_min   = out_ff[2];
   assign rsp_temp_max   = out_ff[3];
   assign rsp_pulse_max  = out_ff[4];
   assign rsp_spo2_max   = out_ff[5];
   assign rsp_temp_mean  = out_ff[6];
   assign rsp_pulse_mean = out_ff[7];
   assign rsp_spo2_mean  = out_ff[8];

endmodule

[hw/rtl/tcrs_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; widths come from its parameters.
module tcrs_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/tcrs_div.sv]
// Restoring unsigned divider that produces one quotient bit per cycle.
// Depends on nothing; the operands must hold steady while it runs.
module tcrs_div #(
   parameter int DIVIDEND_W = 20,
   parameter int DIVISOR_W  = 5
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int STEP_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  fits;

   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = (trial >= {1'b0, divisor});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DIVIDEND_W - 1);
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[dv/tcrs_checker.sv]
// Checker for the three-channel running statistics block: watches both channels,
// predicts each result from the accepted samples and compares it field by field.
// Depends on tcrs_pkg for widths, channel codes and the default window.
module tcrs_checker
   import tcrs_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample_value,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic signed [SAMPLE_W-1:0] rsp_temp_min,
   input  logic signed [SAMPLE_W-1:0] rsp_pulse_min,
   input  logic signed [SAMPLE_W-1:0] rsp_spo2_min,
   input  logic signed [SAMPLE_W-1:0] rsp_temp_max,
   input  logic signed [SAMPLE_W-1:0] rsp_pulse_max,
   input  logic signed [SAMPLE_W-1:0] rsp_spo2_max,
   input  logic signed [SAMPLE_W-1:0] rsp_temp_mean,
   input  logic signed [SAMPLE_W-1:0] rsp_pulse_mean,
   input  logic signed [SAMPLE_W-1:0] rsp_spo2_mean,
   output int                         error_count,
   output int                         pending_count,
   output int                         results_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WINDOW = WINDOW_DEF;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct {
      sample_type mins[NUM_CHAN];
      sample_type maxs[NUM_CHAN];
      sample_type means[NUM_CHAN];
   } stats_type;

   string chan_name[NUM_CHAN] = '{"temp", "pulse", "spo2"};

   logic [CHAN_W-1:0] turn;
   sample_type        held[NUM_CHAN];
   sample_type        ring[WINDOW][NUM_CHAN];
   int                slot;
   int                fill;
   int                sums[NUM_CHAN];
   sample_type        run_min[NUM_CHAN];
   sample_type        run_max[NUM_CHAN];
   stats_type         expected_stats_q[$];
   int                errors;
   int                results;

   task automatic clear_stats();
      turn = CHAN_TEMP;
      slot = 0;
      fill = 0;
      for (int c = 0; c < NUM_CHAN; c++) begin
         held[c]    = '0;
         sums[c]    = 0;
         run_min[c] = '0;
         run_max[c] = '0;
      end
      expected_stats_q.delete();
   endtask

   task automatic absorb_sample(input sample_type value);
      stats_type exp_stats;
      held[turn] = value;
      turn = (turn == CHAN_SPO2) ? CHAN_TEMP : turn + 1'b1;
      for (int c = 0; c < NUM_CHAN; c++) begin
         if (fill >= WINDOW) sums[c] -= ring[slot][c];
         ring[slot][c] = held[c];
         sums[c] += held[c];
         if (fill == 0 || held[c] < run_min[c]) run_min[c] = held[c];
         if (fill == 0 || held[c] > run_max[c]) run_max[c] = held[c];
      end
      slot = (slot == WINDOW - 1) ? 0 : slot + 1;
      if (fill < WINDOW) fill++;
      for (int c = 0; c < NUM_CHAN; c++) begin
         exp_stats.mins[c]  = run_min[c];
         exp_stats.maxs[c]  = run_max[c];
         exp_stats.means[c] = sample_type'(sums[c] / fill);
      end
      expected_stats_q.insert(expected_stats_q.size(), exp_stats);
   endtask

   task automatic compare_field(input string name, input sample_type exp_v,
                                input sample_type act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
         errors++;
      end
   endtask

   task automatic check_result();
      stats_type exp_stats;
      stats_type act_stats;
      act_stats.mins  = '{rsp_temp_min, rsp_pulse_min, rsp_spo2_min};
      act_stats.maxs  = '{rsp_temp_max, rsp_pulse_max, rsp_spo2_max};
      act_stats.means = '{rsp_temp_mean, rsp_pulse_mean, rsp_spo2_mean};
      results++;
      if (expected_stats_q.size() == 0) begin
         $display("%0t: result transfer with no sample outstanding", $time);
         errors++;
      end else begin
         exp_stats = expected_stats_q.pop_front();
         for (int c = 0; c < NUM_CHAN; c++) begin
            compare_field({chan_name[c], "_min"}, exp_stats.mins[c], act_stats.mins[c]);
            compare_field({chan_name[c], "_max"}, exp_stats.maxs[c], act_stats.maxs[c]);
            compare_field({chan_name[c], "_mean"}, exp_stats.means[c], act_stats.means[c]);
         end
      end
   endtask

   // The result side is handled first, so that a result cannot be matched
   // against a sample accepted on the same edge.
   always @(posedge clock) begin
      if (reset) begin
         clear_stats();
      end else begin
         if (rsp_valid && !rsp_stall) check_result();
         if (req_valid && !req_stall) absorb_sample(req_sample_value);
      end
      error_count   <= errors;
      pending_count <= expected_stats_q.size();
      results_seen  <= results;
   end

endmodule

[dv/tb_top.sv]
// Top of the testbench for three_channel_running_stats: clock, reset, sample
// stimulus, result-side stalls and the verdict. Depends on tcrs_pkg and tcrs_checker.
module tb_top;
   import tcrs_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_PER_PHASE = 334;
   localparam int DRAIN_CYCLES     = 100;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef enum {
      GEN_UNIFORM,
      GEN_EXTREME,
      GEN_SMALL,
      GEN_RAIL_HIGH,
      GEN_RAIL_LOW
   } gen_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   sample_type req_sample_value = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   sample_type rsp_temp_min;
   sample_type rsp_pulse_min;
   sample_type rsp_spo2_min;
   sample_type rsp_temp_max;
   sample_type rsp_pulse_max;
   sample_type rsp_spo2_max;
   sample_type rsp_temp_mean;
   sample_type rsp_pulse_mean;
   sample_type rsp_spo2_mean;
   int         error_count;
   int         pending_count;
   int         results_seen;

   int           send_idle_pct = 11;
   int           recv_stall_pct = 79;
   int           samples_sent = 0;
   gen_mode_type gen_mode = GEN_UNIFORM;
   int           run_left = 0;

   int directed_values[$] = '{-32768, 32767, 0, -1, 1, 21845, -21846, 32767, -32768,
                              -32768, 32767, 100, -100, 4095, -4096, 256, 32767, 32767,
                              32767, -32768, -32768, -32768};

   three_channel_running_stats u_dut (.*);

   tcrs_checker u_checker (.*);

   always #6 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   task automatic send_sample(input sample_type value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_sample_value <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      samples_sent++;
   endtask

   // Rail runs hold one extreme long enough to fill the window with it.
   function automatic sample_type pick_sample();
      int pick;
      if (run_left == 0) begin
         pick = $urandom_range(9);
         case (pick)
            0:       gen_mode = GEN_RAIL_HIGH;
            1:       gen_mode = GEN_RAIL_LOW;
            2, 3:    gen_mode = GEN_EXTREME;
            4, 5:    gen_mode = GEN_SMALL;
            default: gen_mode = GEN_UNIFORM;
         endcase
         if (gen_mode == GEN_RAIL_HIGH || gen_mode == GEN_RAIL_LOW)
            run_left = $urandom_range(60, 20);
         else
            run_left = $urandom_range(30, 1);
      end
      run_left--;
      case (gen_mode)
         GEN_RAIL_HIGH: return 16'sh7fff;
         GEN_RAIL_LOW:  return -16'sh8000;
         GEN_EXTREME:   return $urandom_range(1) ? 16'sh7fff : -16'sh8000;
         GEN_SMALL:     return sample_type'($signed($urandom_range(128)) - 64);
         default:       return sample_type'($urandom);
      endcase
   endfunction

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_values[i]) send_sample(sample_type'(directed_values[i]));
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct  = 11;
               recv_stall_pct = 79;
            end
            1: begin
               send_idle_pct  = 79;
               recv_stall_pct = 11;
            end
            default: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
            end
         endcase
         for (int n = 0; n < RANDOM_PER_PHASE; n++) send_sample(pick_sample());
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d samples round robin over temperature, pulse and SpO2, with",
               samples_sent);
      $display("%0d results checked for running min, max and windowed mean.", results_seen);
      if (error_count == 0 && pending_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

[sim.f]
hw/rtl/tcrs_pkg.sv
hw/rtl/tcrs_ram.sv
hw/rtl/tcrs_div.sv
hw/rtl/three_channel_running_stats.sv
dv/tcrs_checker.sv
dv/tb_top.sv
